[rtl/wg_pkg.sv]
`default_nettype none
package wg_pkg;

	localparam logic [2:0] MODE_RECT = 3'd0;
	localparam logic [2:0] MODE_PULSE = 3'd1;
	localparam logic [2:0] MODE_STEP = 3'd2;
	localparam logic [2:0] MODE_TRI = 3'd3;
	localparam logic [2:0] MODE_SINE = 3'd4;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_AMP = 3'd1;
	localparam logic [2:0] REG_DELAY = 3'd2;
	localparam logic [2:0] REG_PERIOD = 3'd3;
	localparam logic [2:0] REG_DUTY = 3'd4;
	localparam logic [2:0] REG_PULSE = 3'd5;

	localparam logic [16:0] DUTY_ONE = 17'd65536;
	localparam logic [14:0] SINE_PEAK = 15'd32767;

	// per-request control carried along the pipe
	typedef struct packed {
		logic v;
		logic act;
	} ctl_t;

endpackage
`default_nettype wire

[rtl/wg_mod_cell.sv]
`default_nettype none
// one restoring remainder step: shifts in one dividend bit
module wg_mod_cell import wg_pkg::*; #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] p,
	input  wire ctl_t         ctl_i,
	input  wire logic [W-1:0] num_i,
	input  wire logic [W-1:0] r_i,
	output ctl_t              ctl_o,
	output logic [W-1:0]      num_o,
	output logic [W-1:0]      r_o
);

	logic [W:0]   rs;
	logic [W:0]   rd;
	logic [W-1:0] rn;

	always_comb begin
		rs = {r_i, num_i[W-1]};
		rd = rs - {1'b0, p};
		rn = (rs >= {1'b0, p}) ? rd[W-1:0] : rs[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_o <= {num_i[W-2:0], 1'b0};
			r_o <= rn;
		end
	end

endmodule
`default_nettype wire

[rtl/wg_muldiv_cell.sv]
`default_nettype none
// one step of floor(m*e/p): handles one multiplier bit, msb first
module wg_muldiv_cell import wg_pkg::*; #(
	parameter int W = 32,
	parameter int MB = 17
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [W-1:0]  p,
	input  wire logic          m_bit,
	input  wire ctl_t          ctl_i,
	input  wire logic [W-1:0]  e_i,
	input  wire logic [W-1:0]  r_i,
	input  wire logic [MB-1:0] q_i,
	output ctl_t               ctl_o,
	output logic [W-1:0]       e_o,
	output logic [W-1:0]       r_o,
	output logic [MB-1:0]      q_o
);

	logic [W:0]    r2;
	logic [W:0]    ra;
	logic [W:0]    sm;
	logic [W:0]    rb;
	logic          g1;
	logic          g2;
	logic [MB-1:0] qn;

	always_comb begin
		r2 = {r_i, 1'b0};
		g1 = (r2 >= {1'b0, p});
		ra = g1 ? (r2 - {1'b0, p}) : r2;
		sm = ra + {1'b0, e_i};
		g2 = m_bit & (sm >= {1'b0, p});
		if (!m_bit) begin
			rb = ra;
		end else if (g2) begin
			rb = sm - {1'b0, p};
		end else begin
			rb = sm;
		end
		qn = {q_i[MB-2:0], 1'b0} + MB'(g1) + MB'(g2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_o <= e_i;
			r_o <= rb[W-1:0];
			q_o <= qn;
		end
	end

endmodule
`default_nettype wire

[rtl/wg_sine_rom.sv]
`default_nettype none
// quarter-wave Q15 table; entry at the full quarter reads as the peak
module wg_sine_rom import wg_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [$clog2(SINE_TABLE_DEPTH):0] addr,
	output logic [14:0]                            data_o
);

	localparam int IB = $clog2(SINE_TABLE_DEPTH);
	localparam logic [IB:0] FULL = (IB+1)'(SINE_TABLE_DEPTH);

	function automatic logic [14:0] entry(input int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		longint      v;
		x = (64'(k) * 64'd1686629713) / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			term = (term * x2) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
		if (v > 32767) begin
			v = 32767;
		end
		return 15'(v);
	endfunction

	logic [14:0] rom_c [SINE_TABLE_DEPTH];

	for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
		assign rom_c[g] = entry(g);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_o <= (addr == FULL) ? SINE_PEAK : rom_c[addr[IB-1:0]];
		end
	end

endmodule
`default_nettype wire

[rtl/multi_mode_waveform_generator.sv]
// Pipe: an entry stage, the remainder chain (one cell per time bit), a fold stage,
// the scaled-division chain (one cell per multiplier bit, MB = max(17, log2(4*depth)+1))
// and a table stage; the two-entry output buffer absorbs a stalled sink.
// Throughput: one request per cycle while that buffer has a free slot.
// Reset: registers return to their reset values, the pipe and the buffer empty.
`default_nettype none
module multi_mode_waveform_generator import wg_pkg::*; #(
	parameter int TIME_BITS = 32,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        time_valid,
	output logic             time_ready,
	input  wire logic [31:0] time_ticks,
	output logic             level_valid,
	input  wire logic        level_ready,
	output logic signed [16:0] level_mv
);

	localparam int W = TIME_BITS;
	localparam int IB = $clog2(SINE_TABLE_DEPTH);
	// multiplier bits: twice the amplitude, or four table lengths for the sine phase
	localparam int MB = (IB + 3 > 17) ? IB + 3 : 17;
	localparam logic [MB-1:0] SINE_M = MB'(4 * SINE_TABLE_DEPTH);
	localparam logic [IB:0] FULL = (IB+1)'(SINE_TABLE_DEPTH);

	// ---------------- configuration registers ----------------
	logic [2:0]  mode_q;
	logic [15:0] amp_q;
	logic [31:0] delay_q;
	logic [31:0] period_q;
	logic [16:0] duty_q;
	logic [31:0] pulse_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RECT;
			amp_q <= '0;
			delay_q <= '0;
			period_q <= 32'd1;
			duty_q <= 17'd32768;
			pulse_q <= '0;
		end else if (wr) begin
			case (paddr[4:2])
				REG_MODE:   mode_q <= pwdata[2:0];
				REG_AMP:    amp_q <= pwdata[15:0];
				REG_DELAY:  delay_q <= pwdata;
				REG_PERIOD: period_q <= pwdata;
				REG_DUTY:   duty_q <= pwdata[16:0];
				REG_PULSE:  pulse_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MODE:   prdata = {29'd0, mode_q};
			REG_AMP:    prdata = {16'd0, amp_q};
			REG_DELAY:  prdata = delay_q;
			REG_PERIOD: prdata = period_q;
			REG_DUTY:   prdata = {15'd0, duty_q};
			REG_PULSE:  prdata = pulse_q;
			default:    prdata = '0;
		endcase
	end

	// time-width views of the registers
	logic [W-1:0] d_m;
	logic [W-1:0] p_m;
	logic [W-1:0] w_m;
	logic [W-1:0] t_m;

	assign d_m = W'(delay_q);
	assign p_m = W'(period_q);
	assign w_m = W'(pulse_q);
	assign t_m = W'(time_ticks);

	// rectangle threshold duty*P/65536, registered: it follows the registers in the next cycle
	logic [16:0]   duty_c;
	logic [W+16:0] prod_hi;
	logic [32:0]   prod_lo;
	logic [W:0]    lim_q;

	always_comb begin
		duty_c = (duty_q > DUTY_ONE) ? DUTY_ONE : duty_q;
		prod_hi = (W+17)'(duty_c) * (W+17)'(p_m >> 16);
		prod_lo = 33'(duty_c) * 33'(p_m[15:0]);
	end

	always_ff @(posedge clk) begin
		lim_q <= (W+1)'(prod_hi) + (W+1)'(prod_lo >> 16);
	end

	// ---------------- flow control ----------------
	logic [1:0] cnt_q;
	logic       en;

	// the pipe moves as long as the output buffer has a free slot
	assign en = (cnt_q != 2'd2);
	assign time_ready = en;

	// ---------------- entry stage ----------------
	logic [W-1:0] tmd;
	logic         act_c;
	ctl_t         ctl_s1;
	logic [W-1:0] num_s1;

	always_comb begin
		tmd = t_m - d_m;
		case (mode_q)
			MODE_RECT:  act_c = (t_m > d_m) && (p_m != '0);
			MODE_PULSE: act_c = (t_m >= d_m) && (tmd <= w_m);
			MODE_STEP:  act_c = (t_m >= d_m);
			MODE_TRI:   act_c = (t_m >= d_m) && (p_m != '0);
			MODE_SINE:  act_c = (t_m >= d_m) && (p_m != '0);
			default:    act_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.v <= time_valid;
			ctl_s1.act <= act_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// sine phase runs from time zero, the others from the delay
			num_s1 <= (mode_q == MODE_SINE) ? t_m : tmd;
		end
	end

	// ---------------- remainder chain: e = num mod P ----------------
	ctl_t         mod_ctl [W+1];
	logic [W-1:0] mod_num [W+1];
	logic [W-1:0] mod_r   [W+1];

	assign mod_ctl[0] = ctl_s1;
	assign mod_num[0] = num_s1;
	assign mod_r[0] = '0;

	for (genvar i = 0; i < W; i++) begin : g_mod
		wg_mod_cell #(.W(W)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.p     (p_m),
			.ctl_i (mod_ctl[i]),
			.num_i (mod_num[i]),
			.r_i   (mod_r[i]),
			.ctl_o (mod_ctl[i+1]),
			.num_o (mod_num[i+1]),
			.r_o   (mod_r[i+1])
		);
	end

	// ---------------- fold stage ----------------
	logic [W-1:0] e_w;
	logic [W-1:0] pe;
	logic [W-1:0] eu_c;
	logic         act_f;
	ctl_t         ctl_s2;
	logic [W-1:0] eu_s2;

	always_comb begin
		e_w = mod_r[W];
		pe = p_m - e_w;
		act_f = mod_ctl[W].act;
		eu_c = e_w;
		case (mode_q)
			MODE_RECT: act_f = mod_ctl[W].act && ({1'b0, e_w} <= lim_q);
			// falling half mirrors onto the rising half
			MODE_TRI:  eu_c = (e_w <= pe) ? e_w : pe;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.v <= mod_ctl[W].v;
			ctl_s2.act <= act_f;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eu_s2 <= eu_c;
		end
	end

	// ---------------- scaled division chain: q = floor(m*e/P) ----------------
	logic [MB-1:0] m_c;

	assign m_c = (mode_q == MODE_SINE) ? SINE_M : MB'({amp_q, 1'b0});

	ctl_t          md_ctl [MB+1];
	logic [W-1:0]  md_e   [MB+1];
	logic [W-1:0]  md_r   [MB+1];
	logic [MB-1:0] md_q   [MB+1];

	assign md_ctl[0] = ctl_s2;
	assign md_e[0] = eu_s2;
	assign md_r[0] = '0;
	assign md_q[0] = '0;

	for (genvar j = 0; j < MB; j++) begin : g_md
		wg_muldiv_cell #(.W(W), .MB(MB)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.p     (p_m),
			.m_bit (m_c[MB-1-j]),
			.ctl_i (md_ctl[j]),
			.e_i   (md_e[j]),
			.r_i   (md_r[j]),
			.q_i   (md_q[j]),
			.ctl_o (md_ctl[j+1]),
			.e_o   (md_e[j+1]),
			.r_o   (md_r[j+1]),
			.q_o   (md_q[j+1])
		);
	end

	// ---------------- table stage ----------------
	logic [1:0]    quad;
	logic [IB-1:0] kidx;
	logic [IB:0]   raddr;
	logic [14:0]   sine_s3;
	ctl_t          ctl_s3;
	logic [15:0]   q_s3;
	logic          neg_s3;

	always_comb begin
		quad = md_q[MB][IB+1:IB];
		kidx = md_q[MB][IB-1:0];
		raddr = quad[0] ? (FULL - {1'b0, kidx}) : {1'b0, kidx};
	end

	wg_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
		.clk   (clk),
		.en    (en),
		.addr  (raddr),
		.data_o(sine_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= md_ctl[MB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3 <= md_q[MB][15:0];
			neg_s3 <= quad[1];
		end
	end

	// ---------------- level ----------------
	logic [30:0] sprod;
	logic [15:0] mag;
	logic        neg;
	logic [16:0] lvl;

	always_comb begin
		sprod = 31'(amp_q) * 31'(sine_s3);
		neg = 1'b0;
		case (mode_q)
			MODE_RECT, MODE_PULSE, MODE_STEP: mag = amp_q;
			MODE_TRI:  mag = q_s3;
			MODE_SINE: begin
				mag = sprod[30:15];
				neg = neg_s3;
			end
			default:   mag = '0;
		endcase
		if (!ctl_s3.act) begin
			mag = '0;
		end
		lvl = neg ? (17'd0 - {1'b0, mag}) : {1'b0, mag};
	end

	// ---------------- output buffer, two entries ----------------
	logic [16:0] b0_q;
	logic [16:0] b1_q;
	logic        push;
	logic        pop;

	assign push = ctl_s3.v & en;
	assign pop = level_valid & level_ready;
	assign level_valid = (cnt_q != 2'd0);
	assign level_mv = b0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					b0_q <= lvl;
				end else begin
					b1_q <= lvl;
				end
			end
			2'b01: b0_q <= b1_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					b0_q <= lvl;
				end else begin
					b0_q <= b1_q;
					b1_q <= lvl;
				end
			end
			default: ;
		endcase
	end

	// ---------------- checks ----------------
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s3.v && cnt_q == 2'd2) |=> ctl_s3.v)
		else $error("request dropped at the end of the pipe");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("result not counted into the buffer");

endmodule
`default_nettype wire
